// ===== rtl/core/cpe_pkg.sv =====
// ----------------------------------------------------------------------------
// cpe_pkg: shared types and constants
// Sizes, function codes, controller states and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cpe_pkg;

  localparam int MAX_SLOTS      = 8;
  localparam int MAX_PARTITIONS = 64;
  localparam int COST_MAX       = 31;
  localparam int COST_W         = 5;
  localparam int CAND_W         = COST_W + 1;
  localparam int SLOT_W         = $clog2(MAX_SLOTS);
  localparam int LVL_W          = (SLOT_W > 0) ? SLOT_W : 1;
  localparam int TAB_DEPTH      = MAX_SLOTS * (COST_MAX + 1);
  localparam int TAB_AW         = LVL_W + COST_W;
  localparam int PACK_SLOTS     = 8;
  localparam int PACK_W         = PACK_SLOTS * COST_W;
  localparam int EMIT_W         = 7;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_RUN  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LEVEL,
    ST_SCAN,
    ST_TEST,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_COMMIT,
    ST_POP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;       // write one count table entry
    logic start_run;  // latch run arguments and seed level 0
    logic set_cand;   // first candidate cost of the current level
    logic read;       // read the count of the current candidate
    logic next_cand;  // step to the next candidate cost
    logic mul_lo;     // low half of product times count
    logic mul_hi;     // high half of product times count
    logic commit;     // push a level, or record a split at the last level
    logic pop;        // back up one level
    logic finish;     // present the final result of the run
  } cmd_t;

  typedef struct packed {
    logic bad_run;
    logic at_cap;
    logic at_last;
    logic cand_ok;
    logic cnt_nonzero;
    logic level_zero;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/cpe_ctrl.sv =====
// ----------------------------------------------------------------------------
// cpe_ctrl: search controller
// Sequences the depth-first walk: candidate scan, count read, split
// multiply, push or record, and backtrack.
// ----------------------------------------------------------------------------
`default_nettype none

module cpe_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic             func,
  input  wire cpe_pkg::status_t status,
  output cpe_pkg::cmd_t         cmd,
  output logic                  busy
);

  cpe_pkg::state_t state;
  cpe_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cpe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cpe_pkg::ST_IDLE: begin
        if (start && func == cpe_pkg::FUNC_RUN) state_next = cpe_pkg::ST_CHECK;
      end
      cpe_pkg::ST_CHECK: begin
        state_next = status.bad_run ? cpe_pkg::ST_FINISH : cpe_pkg::ST_LEVEL;
      end
      cpe_pkg::ST_LEVEL: begin
        state_next = status.at_cap ? cpe_pkg::ST_FINISH : cpe_pkg::ST_SCAN;
      end
      cpe_pkg::ST_SCAN: begin
        state_next = status.cand_ok ? cpe_pkg::ST_TEST : cpe_pkg::ST_POP;
      end
      cpe_pkg::ST_TEST: begin
        priority if (status.cnt_nonzero) state_next = cpe_pkg::ST_MUL_LO;
        else if (status.at_last)         state_next = cpe_pkg::ST_POP;
        else                             state_next = cpe_pkg::ST_SCAN;
      end
      cpe_pkg::ST_MUL_LO: state_next = cpe_pkg::ST_MUL_HI;
      cpe_pkg::ST_MUL_HI: state_next = cpe_pkg::ST_COMMIT;
      cpe_pkg::ST_COMMIT: begin
        state_next = status.at_last ? cpe_pkg::ST_POP : cpe_pkg::ST_LEVEL;
      end
      cpe_pkg::ST_POP: begin
        state_next = status.level_zero ? cpe_pkg::ST_FINISH : cpe_pkg::ST_LEVEL;
      end
      cpe_pkg::ST_FINISH: state_next = cpe_pkg::ST_IDLE;
      default: state_next = cpe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      cpe_pkg::ST_IDLE: begin
        busy          = 1'b0;
        cmd.load      = start && func == cpe_pkg::FUNC_LOAD;
        cmd.start_run = start && func == cpe_pkg::FUNC_RUN;
      end
      cpe_pkg::ST_CHECK:  ;
      cpe_pkg::ST_LEVEL:  cmd.set_cand = !status.at_cap;
      cpe_pkg::ST_SCAN:   cmd.read = status.cand_ok;
      cpe_pkg::ST_TEST:   cmd.next_cand = !status.cnt_nonzero && !status.at_last;
      cpe_pkg::ST_MUL_LO: cmd.mul_lo = 1'b1;
      cpe_pkg::ST_MUL_HI: cmd.mul_hi = 1'b1;
      cpe_pkg::ST_COMMIT: cmd.commit = 1'b1;
      cpe_pkg::ST_POP:    cmd.pop = !status.level_zero;
      cpe_pkg::ST_FINISH: cmd.finish = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/cpe_datapath.sv =====
// ----------------------------------------------------------------------------
// cpe_datapath: search datapath
// Count table memory, per-level stack, split multiplier, keyspace
// accumulator, pending result and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module cpe_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire cpe_pkg::cmd_t                cmd,
  output cpe_pkg::status_t                  status,
  input  wire logic [2:0]                   slot,
  input  wire logic [4:0]                   cost_index,
  input  wire logic [31:0]                  count_value,
  input  wire logic [3:0]                   token_count,
  input  wire logic [7:0]                   goal_cost,
  output logic                              result_strobe,
  output logic                              valid_res,
  output logic [cpe_pkg::PACK_W-1:0]        packed_costs,
  output logic [63:0]                       combinations,
  output logic [63:0]                       range_start,
  output logic [63:0]                       range_end,
  output logic                              last
);

  localparam int LW = cpe_pkg::LVL_W;
  localparam int CW = cpe_pkg::CAND_W;

  // count table
  logic [31:0]                  tab [cpe_pkg::TAB_DEPTH];
  logic [31:0]                  rdata;
  logic [cpe_pkg::TAB_AW-1:0]   waddr;
  logic [cpe_pkg::TAB_AW-1:0]   raddr;

  // run arguments and search stack
  logic [3:0]                   n_reg;
  logic [7:0]                   tgt;
  logic [LW-1:0]                lvl;
  logic [LW-1:0]                last_lvl;
  logic [CW-1:0]                cand;
  logic [CW-1:0]                next_cost [cpe_pkg::MAX_SLOTS];
  logic [7:0]                   remaining [cpe_pkg::MAX_SLOTS];
  logic [63:0]                  product   [cpe_pkg::MAX_SLOTS];
  logic [cpe_pkg::COST_W-1:0]   chosen    [cpe_pkg::MAX_SLOTS];

  logic [63:0]                  mul_lo_r;
  logic [31:0]                  mul_hi_r;
  logic [63:0]                  keyspace;
  logic [cpe_pkg::EMIT_W-1:0]   emitted;

  logic                         pend_valid;
  logic [cpe_pkg::PACK_W-1:0]   pend_packed;
  logic [63:0]                  pend_comb;
  logic [63:0]                  pend_start;
  logic [63:0]                  pend_end;

  // current level view
  logic [7:0]                   rem;
  logic [CW-1:0]                nc;
  logic [63:0]                  prod_cur;
  logic [LW-1:0]                after;
  logic [8:0]                   span;
  logic [8:0]                   lo;
  logic [8:0]                   c0;
  logic [CW-1:0]                cand_start;
  logic [CW-1:0]                maxc;
  logic [31:0]                  hi_full;
  logic [63:0]                  new_prod;
  logic [63:0]                  key_sum;
  logic [cpe_pkg::PACK_W-1:0]   packed_new;

  assign waddr = {LW'(slot), cost_index};
  assign raddr = {lvl, cand[cpe_pkg::COST_W-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.load && {1'b0, slot} < 4'(cpe_pkg::MAX_SLOTS)) begin
      tab[waddr] <= count_value;
    end
    if (cmd.read) begin
      rdata <= tab[raddr];
    end
  end

  assign rem      = remaining[lvl];
  assign nc       = next_cost[lvl];
  assign prod_cur = product[lvl];
  assign after    = last_lvl - lvl;
  assign span     = 9'(after) * 9'(cpe_pkg::COST_MAX);

  // candidate cost bounds; the first keeps deeper slots reachable
  always_comb begin
    lo = ({1'b0, rem} > span) ? ({1'b0, rem} - span) : 9'd0;
    c0 = (lo > 9'(nc)) ? lo : 9'(nc);
    cand_start = (c0 > 9'(cpe_pkg::COST_MAX + 1)) ? CW'(cpe_pkg::COST_MAX + 1) : c0[CW-1:0];
    maxc = (rem > 8'(cpe_pkg::COST_MAX)) ? CW'(cpe_pkg::COST_MAX) : rem[CW-1:0];
  end

  assign hi_full  = prod_cur[63:32] * rdata;
  assign new_prod = mul_lo_r + {mul_hi_r, 32'd0};
  assign key_sum  = keyspace + new_prod;

  always_comb begin
    packed_new = '0;
    for (int i = 0; i < cpe_pkg::PACK_SLOTS; i++) begin
      if (i < cpe_pkg::MAX_SLOTS) begin
        packed_new[i*cpe_pkg::COST_W +: cpe_pkg::COST_W] =
          (LW'(i) == lvl) ? cand[cpe_pkg::COST_W-1:0] : chosen[i];
      end
    end
  end

  always_comb begin
    status.bad_run     = (n_reg == 4'd0) || ({1'b0, n_reg} > 5'(cpe_pkg::MAX_SLOTS)) ||
                         (9'(tgt) > 9'(n_reg) * 9'(cpe_pkg::COST_MAX));
    status.at_cap      = emitted == cpe_pkg::EMIT_W'(cpe_pkg::MAX_PARTITIONS);
    status.at_last     = lvl == last_lvl;
    status.cand_ok     = cand <= maxc;
    status.cnt_nonzero = rdata != 32'd0;
    status.level_zero  = lvl == '0;
  end

  // stack and search registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lvl <= '0;
    end else if (cmd.start_run) begin
      lvl <= '0;
    end else if (cmd.commit && !status.at_last) begin
      lvl <= lvl + LW'(1);
    end else if (cmd.pop) begin
      lvl <= lvl - LW'(1);
    end

    if (cmd.start_run) begin
      n_reg        <= token_count;
      tgt          <= goal_cost;
      last_lvl     <= LW'(token_count - 4'd1);
      remaining[0] <= goal_cost;
      product[0]   <= 64'd1;
      next_cost[0] <= '0;
      for (int i = 0; i < cpe_pkg::MAX_SLOTS; i++) begin
        chosen[i] <= '0;
      end
    end

    if (cmd.set_cand)  cand <= cand_start;
    if (cmd.next_cand) cand <= cand + CW'(1);
    if (cmd.mul_lo)    mul_lo_r <= 64'(prod_cur[31:0]) * 64'(rdata);
    if (cmd.mul_hi)    mul_hi_r <= hi_full;

    if (cmd.commit) begin
      chosen[lvl] <= cand[cpe_pkg::COST_W-1:0];
      if (!status.at_last) begin
        next_cost[lvl]              <= cand + CW'(1);
        remaining[lvl + LW'(1)]     <= rem - 8'(cand);
        next_cost[lvl + LW'(1)]     <= '0;
        product[lvl + LW'(1)]       <= new_prod;
      end
    end
  end

  // keyspace, pending split and output registers
  always_ff @(posedge clk) begin
    if (rst) begin
      emitted       <= '0;
      keyspace      <= '0;
      pend_valid    <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= (cmd.commit && status.at_last && pend_valid) || cmd.finish;
      if (cmd.start_run) begin
        emitted    <= '0;
        keyspace   <= '0;
        pend_valid <= 1'b0;
      end
      // hold each split until the next one shows it is not the last
      if (cmd.commit && status.at_last) begin
        emitted     <= emitted + cpe_pkg::EMIT_W'(1);
        keyspace    <= key_sum;
        pend_valid  <= 1'b1;
        pend_packed <= packed_new;
        pend_comb   <= new_prod;
        pend_start  <= keyspace;
        pend_end    <= key_sum;
        if (pend_valid) begin
          valid_res     <= 1'b1;
          packed_costs  <= pend_packed;
          combinations  <= pend_comb;
          range_start   <= pend_start;
          range_end     <= pend_end;
          last          <= 1'b0;
        end
      end
      if (cmd.finish) begin
        valid_res     <= pend_valid;
        packed_costs  <= pend_valid ? pend_packed : '0;
        combinations  <= pend_valid ? pend_comb : 64'd0;
        range_start   <= pend_valid ? pend_start : 64'd0;
        range_end     <= pend_valid ? pend_end : 64'd0;
        last          <= 1'b1;
        pend_valid    <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cost_partition_enumerator.sv =====
// ----------------------------------------------------------------------------
// cost_partition_enumerator: split enumeration over a slot count table
// Walks the splits of a target cost into per-slot costs with nonzero
// counts, up to 64 splits, and reports product and keyspace range for each split.
// ----------------------------------------------------------------------------
// Usage: raise start with func and its arguments while busy is low; the
// transaction is taken at that edge. A load transaction writes one count
// entry and gives no result. A run transaction sets busy until
// its final result is out. Results appear on the result ports for a single
// cycle with result_strobe high; the final one has last set, and a run that
// is malformed or finds nothing gives a single result with valid_res low.
// The receiver cannot stall, so nothing is ever held off.
// Steps of a run: a setup check, then for each candidate cost tested
// against the count table a read through its read port and a check, for
// each candidate taken two 32x32 multiplier passes and the commit, a
// step for each level entry, a scan that finds a level exhausted, a step
// for each backtrack, and a closing step. Each split is shown when the
// next one is found, so results come out with the search and the last
// one appears in the cycle after the closing one.
// Reset clears the controller and the result strobe; the count table holds
// no defined value until written.
// ----------------------------------------------------------------------------
`default_nettype none

module cost_partition_enumerator (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  func,
  input  wire logic [2:0]            slot,
  input  wire logic [4:0]            cost_index,
  input  wire logic [31:0]           count_value,
  input  wire logic [3:0]            token_count,
  input  wire logic [7:0]            goal_cost,
  output logic                       result_strobe,
  output logic                       valid_res,
  output logic [39:0]                packed_costs,
  output logic [63:0]                combinations,
  output logic [63:0]                range_start,
  output logic [63:0]                range_end,
  output logic                       last
);

  cpe_pkg::cmd_t    cmd;
  cpe_pkg::status_t status;

  cpe_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .func   (func),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  cpe_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .slot          (slot),
    .cost_index    (cost_index),
    .count_value   (count_value),
    .token_count   (token_count),
    .goal_cost     (goal_cost),
    .result_strobe (result_strobe),
    .valid_res     (valid_res),
    .packed_costs  (packed_costs),
    .combinations  (combinations),
    .range_start   (range_start),
    .range_end     (range_end),
    .last          (last)
  );

  a_run_goes_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && func == cpe_pkg::FUNC_RUN |=> busy)
    else $error("run transaction did not raise busy");

  a_mid_result_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !last |-> busy)
    else $error("non-final result outside a run");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    result_strobe && last |-> !busy)
    else $error("final result while the run is still active");

  a_invalid_is_last: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !valid_res |-> last)
    else $error("invalid result not marked last");

endmodule

`default_nettype wire
